// ===== rtl/core/swsv_pkg.sv =====
// Shared constants and types for the sliding window score vote unit.
package swsv_pkg;

    localparam int MAX_WINDOW    = 64;
    localparam int MAX_CLASSES   = 16;
    localparam int SCORE_BITS    = 16;

    localparam int SLOT_BITS     = $clog2(MAX_WINDOW);
    localparam int CLASS_BITS    = $clog2(MAX_CLASSES);
    localparam int FILL_BITS     = $clog2(MAX_WINDOW + 1);
    localparam int NCLS_BITS     = $clog2(MAX_CLASSES + 1);
    localparam int SUM_BITS      = SCORE_BITS + SLOT_BITS + 1;
    localparam int ADDR_BITS     = SLOT_BITS + CLASS_BITS;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 7;
    localparam int PCT_BITS      = 7;
    localparam int PROD_BITS     = FILL_BITS + PCT_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_NUM_CLASSES = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_LEN  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_FILL    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_VOTE_RATIO  = 2'd3;

    localparam logic CMD_SCORE = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic [PCT_BITS-1:0] PERCENT = PCT_BITS'(100);

    typedef struct packed {
        logic                   score_we;
        logic [ADDR_BITS-1:0]   score_addr;
        logic [SCORE_BITS-1:0]  score_data;
        logic                   win_we;
        logic [SLOT_BITS-1:0]   win_addr;
        logic [CLASS_BITS-1:0]  win_data;
    } store_wr_t;

endpackage

// ===== rtl/core/swsv_window_store.sv =====
// Window memories: per-slot class scores and per-slot vector winners.
module swsv_window_store (
    input  logic                               clk,
    input  swsv_pkg::store_wr_t                wr,
    input  logic [swsv_pkg::SLOT_BITS-1:0]     rd_slot,
    input  logic [swsv_pkg::CLASS_BITS-1:0]    rd_class,
    output logic [swsv_pkg::SCORE_BITS-1:0]    rd_score,
    output logic [swsv_pkg::CLASS_BITS-1:0]    rd_winner
);

    logic [swsv_pkg::SCORE_BITS-1:0] score_mem [swsv_pkg::MAX_WINDOW*swsv_pkg::MAX_CLASSES];
    logic [swsv_pkg::CLASS_BITS-1:0] win_mem   [swsv_pkg::MAX_WINDOW];

    always_ff @(posedge clk)
    begin
        if (wr.score_we)
        begin
            score_mem[wr.score_addr] <= wr.score_data;
        end
        rd_score <= score_mem[{rd_slot, rd_class}];
    end

    always_ff @(posedge clk)
    begin
        if (wr.win_we)
        begin
            win_mem[wr.win_addr] <= wr.win_data;
        end
        rd_winner <= win_mem[rd_slot];
    end

endmodule

// ===== rtl/core/sliding_window_score_vote_unit.sv =====
// Sliding window score vote unit: top level with sequencer, sums, votes and result register.
// Sequence: a score request passes through the update state and then returns to idle; the last
// score of a vector adds a vote state, a scan of each class in turn and an output state, and the
// scan and output are skipped while the fill stays below min_fill; a clear request is done in idle.
// in_stall is high while a request is in progress and while a new result waits for a stalled one.
// Reset (rst_n, asynchronous, active low) empties the window and restores the registers.
module sliding_window_score_vote_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [swsv_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [swsv_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  cmd,
    input  logic signed [swsv_pkg::SCORE_BITS-1:0] score,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [swsv_pkg::CLASS_BITS-1:0]       class_index,
    output logic                                  unknown,
    output logic [swsv_pkg::FILL_BITS-1:0]        top_votes,
    output logic [swsv_pkg::FILL_BITS-1:0]        fill
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_VOTE,
        S_SCAN,
        S_OUT
    } state_t;

    localparam logic signed [swsv_pkg::SCORE_BITS-1:0] SCORE_MIN =
        {1'b1, {(swsv_pkg::SCORE_BITS-1){1'b0}}};

    state_t                                 state_reg, state_next;

    logic [swsv_pkg::NCLS_BITS-1:0]         ncls_reg, ncls_next;
    logic [swsv_pkg::FILL_BITS-1:0]         wlen_reg, wlen_next;
    logic [swsv_pkg::FILL_BITS-1:0]         min_fill_reg, min_fill_next;
    logic [swsv_pkg::PCT_BITS-1:0]          ratio_reg, ratio_next;

    logic signed [swsv_pkg::SUM_BITS-1:0]   sums_reg  [swsv_pkg::MAX_CLASSES];
    logic signed [swsv_pkg::SUM_BITS-1:0]   sums_next [swsv_pkg::MAX_CLASSES];
    logic [swsv_pkg::FILL_BITS-1:0]         votes_reg  [swsv_pkg::MAX_CLASSES];
    logic [swsv_pkg::FILL_BITS-1:0]         votes_next [swsv_pkg::MAX_CLASSES];

    logic [swsv_pkg::FILL_BITS-1:0]         wfill_reg, wfill_next;
    logic [swsv_pkg::SLOT_BITS-1:0]         slot_reg, slot_next;
    logic [swsv_pkg::CLASS_BITS-1:0]        cpos_reg, cpos_next;
    logic signed [swsv_pkg::SCORE_BITS-1:0] vmax_reg, vmax_next;
    logic [swsv_pkg::CLASS_BITS-1:0]        vmax_cls_reg, vmax_cls_next;

    logic signed [swsv_pkg::SCORE_BITS-1:0] score_reg, score_next;
    logic                                   full_reg, full_next;

    logic [swsv_pkg::CLASS_BITS-1:0]        scan_reg, scan_next;
    logic [swsv_pkg::CLASS_BITS-1:0]        best_reg, best_next;
    logic signed [swsv_pkg::SUM_BITS-1:0]   best_sum_reg, best_sum_next;
    logic [swsv_pkg::FILL_BITS-1:0]         top_reg, top_next;

    logic                                   out_valid_reg, out_valid_next;
    logic [swsv_pkg::CLASS_BITS-1:0]        out_cls_reg, out_cls_next;
    logic                                   out_unk_reg, out_unk_next;
    logic [swsv_pkg::FILL_BITS-1:0]         out_top_reg, out_top_next;
    logic [swsv_pkg::FILL_BITS-1:0]         out_fill_reg, out_fill_next;

    logic [swsv_pkg::NCLS_BITS-1:0]         eff_nc;
    logic [swsv_pkg::FILL_BITS-1:0]         eff_wl;
    logic [swsv_pkg::CLASS_BITS-1:0]        last_cls;
    logic                                   in_accept;
    logic                                   out_free;
    logic [swsv_pkg::CLASS_BITS-1:0]        sum_sel;
    logic signed [swsv_pkg::SUM_BITS-1:0]   sum_rd;
    logic [swsv_pkg::FILL_BITS-1:0]         vote_rd;
    logic signed [swsv_pkg::SUM_BITS-1:0]   score_ext;
    logic signed [swsv_pkg::SUM_BITS-1:0]   old_ext;
    logic [swsv_pkg::FILL_BITS-1:0]         fill_inc;
    logic [swsv_pkg::PROD_BITS-1:0]         lhs_prod;
    logic [swsv_pkg::PROD_BITS-1:0]         rhs_prod;

    swsv_pkg::store_wr_t                    store_wr;
    logic [swsv_pkg::SCORE_BITS-1:0]        rd_score;
    logic [swsv_pkg::CLASS_BITS-1:0]        rd_winner;

    swsv_window_store u_store (
        .clk       (clk),
        .wr        (store_wr),
        .rd_slot   (slot_reg),
        .rd_class  (cpos_reg),
        .rd_score  (rd_score),
        .rd_winner (rd_winner)
    );

    assign in_stall    = (state_reg != S_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign class_index = out_cls_reg;
    assign unknown     = out_unk_reg;
    assign top_votes   = out_top_reg;
    assign fill        = out_fill_reg;

    always_comb
    begin
        if (ncls_reg == '0)
        begin
            eff_nc = swsv_pkg::NCLS_BITS'(1);
        end
        else if (ncls_reg > swsv_pkg::NCLS_BITS'(swsv_pkg::MAX_CLASSES))
        begin
            eff_nc = swsv_pkg::NCLS_BITS'(swsv_pkg::MAX_CLASSES);
        end
        else
        begin
            eff_nc = ncls_reg;
        end
        if (wlen_reg == '0)
        begin
            eff_wl = swsv_pkg::FILL_BITS'(1);
        end
        else if (wlen_reg > swsv_pkg::FILL_BITS'(swsv_pkg::MAX_WINDOW))
        begin
            eff_wl = swsv_pkg::FILL_BITS'(swsv_pkg::MAX_WINDOW);
        end
        else
        begin
            eff_wl = wlen_reg;
        end
    end

    assign last_cls  = swsv_pkg::CLASS_BITS'(eff_nc - swsv_pkg::NCLS_BITS'(1));
    assign sum_sel   = (state_reg == S_SCAN) ? scan_reg : cpos_reg;
    assign sum_rd    = sums_reg[sum_sel];
    assign vote_rd   = votes_reg[scan_reg];
    assign score_ext = swsv_pkg::SUM_BITS'(score_reg);
    assign old_ext   = full_reg ? swsv_pkg::SUM_BITS'($signed(rd_score)) : '0;
    assign fill_inc  = full_reg ? wfill_reg : wfill_reg + swsv_pkg::FILL_BITS'(1);
    assign lhs_prod  = swsv_pkg::PROD_BITS'(top_reg) * swsv_pkg::PROD_BITS'(swsv_pkg::PERCENT);
    assign rhs_prod  = swsv_pkg::PROD_BITS'(ratio_reg) * swsv_pkg::PROD_BITS'(wfill_reg);

    always_comb
    begin
        state_next    = state_reg;
        ncls_next     = ncls_reg;
        wlen_next     = wlen_reg;
        min_fill_next = min_fill_reg;
        ratio_next    = ratio_reg;
        sums_next     = sums_reg;
        votes_next    = votes_reg;
        wfill_next    = wfill_reg;
        slot_next     = slot_reg;
        cpos_next     = cpos_reg;
        vmax_next     = vmax_reg;
        vmax_cls_next = vmax_cls_reg;
        score_next    = score_reg;
        full_next     = full_reg;
        scan_next     = scan_reg;
        best_next     = best_reg;
        best_sum_next = best_sum_reg;
        top_next      = top_reg;
        out_valid_next = out_valid_reg;
        out_cls_next  = out_cls_reg;
        out_unk_next  = out_unk_reg;
        out_top_next  = out_top_reg;
        out_fill_next = out_fill_reg;

        store_wr            = '0;
        store_wr.score_addr = {slot_reg, cpos_reg};
        store_wr.score_data = score_reg;
        store_wr.win_addr   = slot_reg;
        store_wr.win_data   = vmax_cls_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_wr_en)
        begin
            case (cfg_index)
                swsv_pkg::REG_NUM_CLASSES: ncls_next = cfg_data[swsv_pkg::NCLS_BITS-1:0];
                swsv_pkg::REG_WINDOW_LEN:  wlen_next = cfg_data;
                swsv_pkg::REG_MIN_FILL:    min_fill_next = cfg_data;
                swsv_pkg::REG_VOTE_RATIO:  ratio_next = cfg_data;
                default: ;
            endcase
            if (cfg_index == swsv_pkg::REG_NUM_CLASSES ||
                cfg_index == swsv_pkg::REG_WINDOW_LEN)
            begin
                for (int i = 0; i < swsv_pkg::MAX_CLASSES; i++)
                begin
                    sums_next[i]  = '0;
                    votes_next[i] = '0;
                end
                wfill_next    = '0;
                slot_next     = '0;
                cpos_next     = '0;
                vmax_next     = SCORE_MIN;
                vmax_cls_next = '0;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (cmd == swsv_pkg::CMD_CLEAR)
                    begin
                        for (int i = 0; i < swsv_pkg::MAX_CLASSES; i++)
                        begin
                            sums_next[i]  = '0;
                            votes_next[i] = '0;
                        end
                        wfill_next    = '0;
                        slot_next     = '0;
                        cpos_next     = '0;
                        vmax_next     = SCORE_MIN;
                        vmax_cls_next = '0;
                    end
                    else
                    begin
                        score_next = score;
                        full_next  = (wfill_reg >= eff_wl);
                        state_next = S_UPD;
                    end
                end
            end

            S_UPD:
            begin
                sums_next[cpos_reg] = sum_rd + score_ext - old_ext;
                store_wr.score_we   = 1'b1;
                if (cpos_reg == '0 || score_reg > vmax_reg)
                begin
                    vmax_next     = score_reg;
                    vmax_cls_next = cpos_reg;
                end
                if (cpos_reg == last_cls)
                begin
                    cpos_next  = '0;
                    state_next = S_VOTE;
                end
                else
                begin
                    cpos_next  = cpos_reg + swsv_pkg::CLASS_BITS'(1);
                    state_next = S_IDLE;
                end
            end

            S_VOTE:
            begin
                for (int i = 0; i < swsv_pkg::MAX_CLASSES; i++)
                begin
                    votes_next[i] = votes_reg[i]
                        + ((vmax_cls_reg == swsv_pkg::CLASS_BITS'(i)) ?
                           swsv_pkg::FILL_BITS'(1) : '0)
                        - ((full_reg && rd_winner == swsv_pkg::CLASS_BITS'(i) &&
                            votes_reg[i] != '0) ? swsv_pkg::FILL_BITS'(1) : '0);
                end
                store_wr.win_we = 1'b1;
                wfill_next      = fill_inc;
                if (swsv_pkg::FILL_BITS'(slot_reg) + swsv_pkg::FILL_BITS'(1) >= eff_wl)
                begin
                    slot_next = '0;
                end
                else
                begin
                    slot_next = slot_reg + swsv_pkg::SLOT_BITS'(1);
                end
                vmax_next     = SCORE_MIN;
                vmax_cls_next = '0;
                scan_next     = '0;
                if (fill_inc >= min_fill_reg)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_SCAN:
            begin
                if (scan_reg == '0 || sum_rd > best_sum_reg)
                begin
                    best_next     = scan_reg;
                    best_sum_next = sum_rd;
                end
                if (scan_reg == '0 || vote_rd > top_reg)
                begin
                    top_next = vote_rd;
                end
                if (scan_reg == last_cls)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    scan_next = scan_reg + swsv_pkg::CLASS_BITS'(1);
                end
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_cls_next   = best_reg;
                    out_unk_next   = (lhs_prod < rhs_prod);
                    out_top_next   = top_reg;
                    out_fill_next  = wfill_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ncls_reg      <= swsv_pkg::NCLS_BITS'(2);
            wlen_reg      <= swsv_pkg::FILL_BITS'(50);
            min_fill_reg  <= swsv_pkg::FILL_BITS'(10);
            ratio_reg     <= swsv_pkg::PCT_BITS'(20);
            for (int i = 0; i < swsv_pkg::MAX_CLASSES; i++)
            begin
                sums_reg[i]  <= '0;
                votes_reg[i] <= '0;
            end
            wfill_reg     <= '0;
            slot_reg      <= '0;
            cpos_reg      <= '0;
            vmax_reg      <= SCORE_MIN;
            vmax_cls_reg  <= '0;
            full_reg      <= 1'b0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
            score_reg     <= '0;
            best_reg      <= '0;
            best_sum_reg  <= '0;
            top_reg       <= '0;
            out_cls_reg   <= '0;
            out_unk_reg   <= 1'b0;
            out_top_reg   <= '0;
            out_fill_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ncls_reg      <= ncls_next;
            wlen_reg      <= wlen_next;
            min_fill_reg  <= min_fill_next;
            ratio_reg     <= ratio_next;
            sums_reg      <= sums_next;
            votes_reg     <= votes_next;
            wfill_reg     <= wfill_next;
            slot_reg      <= slot_next;
            cpos_reg      <= cpos_next;
            vmax_reg      <= vmax_next;
            vmax_cls_reg  <= vmax_cls_next;
            full_reg      <= full_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
            score_reg     <= score_next;
            best_reg      <= best_next;
            best_sum_reg  <= best_sum_next;
            top_reg       <= top_next;
            out_cls_reg   <= out_cls_next;
            out_unk_reg   <= out_unk_next;
            out_top_reg   <= out_top_next;
            out_fill_reg  <= out_fill_next;
        end
    end

`ifndef SYNTHESIS
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && cmd == swsv_pkg::CMD_CLEAR |=> wfill_reg == '0 && cpos_reg == '0)
        else $error("clear request did not empty the window");

    a_result_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> out_fill_reg >= min_fill_reg && out_top_reg <= out_fill_reg)
        else $error("result given with fill below minimum or votes above fill");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_VOTE |=> wfill_reg <= eff_wl && wfill_reg != '0)
        else $error("window fill outside its range after a vector closed");
`endif

endmodule
